// ----- rtl/core/ates_pkg.sv -----
`timescale 1ns / 1ps
package ates_pkg;

   localparam int COLS_DEF       = 80;
   localparam int ROWS_DEF       = 24;
   localparam int MAX_ARGS_DEF   = 16;
   localparam int SEQ_WINDOW_DEF = 20;
   localparam int TAB_STOP_DEF   = 8;
   localparam int COL_W_DEF      = 7;
   localparam int ROW_W_DEF      = 5;

   localparam int BYTE_W   = 8;
   localparam int CHAR_W   = 7;
   localparam int ATTR_W   = 8;
   localparam int COLOUR_W = 4;
   localparam int STYLE_W  = 3;
   localparam int NUM_W    = 16;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   localparam logic [NUM_W-1:0]    NUM_MAX        = 16'hFFFF;
   localparam logic [COLOUR_W-1:0] DEFAULT_COLOUR = 4'd9;
   localparam logic [CHAR_W-1:0]   CHAR_SPACE     = 7'd32;

   localparam logic [STYLE_W-1:0] STYLE_BOLD  = 3'h1;
   localparam logic [STYLE_W-1:0] STYLE_UNDER = 3'h2;
   localparam logic [STYLE_W-1:0] STYLE_REV   = 3'h4;

   localparam logic [BYTE_W-1:0] BYTE_TAB   = 8'd9;
   localparam logic [BYTE_W-1:0] BYTE_LF    = 8'd10;
   localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'd27;
   localparam logic [BYTE_W-1:0] BYTE_PR_LO = 8'd32;
   localparam logic [BYTE_W-1:0] BYTE_PR_HI = 8'd126;
   localparam logic [BYTE_W-1:0] BYTE_LBRK  = 8'h5B;
   localparam logic [BYTE_W-1:0] BYTE_SEMI  = 8'h3B;
   localparam logic [BYTE_W-1:0] BYTE_D0    = 8'h30;
   localparam logic [BYTE_W-1:0] BYTE_D9    = 8'h39;
   localparam logic [BYTE_W-1:0] BYTE_UC_A  = 8'h41;
   localparam logic [BYTE_W-1:0] BYTE_UC_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] BYTE_LC_A  = 8'h61;
   localparam logic [BYTE_W-1:0] BYTE_LC_Z  = 8'h7A;

   localparam logic [BYTE_W-1:0] LT_UP      = 8'h41;
   localparam logic [BYTE_W-1:0] LT_DOWN    = 8'h42;
   localparam logic [BYTE_W-1:0] LT_RIGHT   = 8'h43;
   localparam logic [BYTE_W-1:0] LT_LEFT    = 8'h44;
   localparam logic [BYTE_W-1:0] LT_HOME    = 8'h48;
   localparam logic [BYTE_W-1:0] LT_HOME_F  = 8'h66;
   localparam logic [BYTE_W-1:0] LT_CLEAR   = 8'h4A;
   localparam logic [BYTE_W-1:0] LT_ERASE   = 8'h4B;
   localparam logic [BYTE_W-1:0] LT_SGR     = 8'h6D;
   localparam logic [BYTE_W-1:0] LT_SAVE    = 8'h73;
   localparam logic [BYTE_W-1:0] LT_RESTORE = 8'h75;

   localparam logic [NUM_W-1:0] SGR_RESET = 16'd0;
   localparam logic [NUM_W-1:0] SGR_BOLD  = 16'd1;
   localparam logic [NUM_W-1:0] SGR_UNDER = 16'd4;
   localparam logic [NUM_W-1:0] SGR_REV   = 16'd7;
   localparam logic [NUM_W-1:0] SGR_FG_LO = 16'd30;
   localparam logic [NUM_W-1:0] SGR_FG_HI = 16'd37;
   localparam logic [NUM_W-1:0] SGR_FG_DF = 16'd39;
   localparam logic [NUM_W-1:0] SGR_BG_LO = 16'd40;
   localparam logic [NUM_W-1:0] SGR_BG_HI = 16'd47;
   localparam logic [NUM_W-1:0] SGR_BG_DF = 16'd49;
   localparam logic [NUM_W-1:0] ARG_CLEAR_ALL = 16'd2;
   localparam logic [NUM_W-1:0] ARG_TO_END    = 16'd0;

   typedef enum logic [5:0] {
      ST_FILL   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_LOAD   = 6'b001000,
      ST_SCROLL = 6'b010000,
      ST_SGR    = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      PH_TEXT = 3'b001,
      PH_ESC  = 3'b010,
      PH_CSI  = 3'b100
   } phase_type;

endpackage

// ----- rtl/core/ates_if.sv -----
`timescale 1ns / 1ps
interface ates_req_if #(
   parameter int COL_W = ates_pkg::COL_W_DEF,
   parameter int ROW_W = ates_pkg::ROW_W_DEF
);
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [7:0]       data_byte;
   logic [ROW_W-1:0] read_row;
   logic [COL_W-1:0] read_col;

   modport source (output valid, cmd, data_byte, read_row, read_col, input ready);
   modport sink   (input valid, cmd, data_byte, read_row, read_col, output ready);
endinterface

interface ates_rsp_if #(
   parameter int COL_W = ates_pkg::COL_W_DEF,
   parameter int ROW_W = ates_pkg::ROW_W_DEF
);
   logic             valid;
   logic             ready;
   logic [6:0]       cell_char;
   logic [7:0]       cell_attr;
   logic [COL_W-1:0] cursor_col;
   logic [ROW_W-1:0] cursor_row;
   logic [3:0]       fore_colour;
   logic [3:0]       back_colour;

   modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row,
                   fore_colour, back_colour, input ready);
   modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row,
                   fore_colour, back_colour, output ready);
endinterface

// ----- rtl/core/ates_ram.sv -----
`timescale 1ns / 1ps
module ates_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/ansi_text_screen_engine.sv -----
`timescale 1ns / 1ps
// Text screen engine for an ANSI escape byte stream. Characters and attributes live in one
// single-port-write RAM of ROWS*COLS cells. After reset the block clears the screen, one
// cell a cycle, before it takes its first word. A cell read passes through the RAM address
// register, the RAM data register and the output register to its response word. Scrolling
// copies the screen through the RAM port one cell a cycle; clear screen and erase to end of
// line go through the same fill, and a graphics sequence handles its parameters in turn.
module ansi_text_screen_engine #(
   parameter int COLS       = ates_pkg::COLS_DEF,
   parameter int ROWS       = ates_pkg::ROWS_DEF,
   parameter int MAX_ARGS   = ates_pkg::MAX_ARGS_DEF,
   parameter int SEQ_WINDOW = ates_pkg::SEQ_WINDOW_DEF,
   parameter int TAB_STOP   = ates_pkg::TAB_STOP_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ates_req_if.sink     req_if,
   ates_rsp_if.source   rsp_if
);
   import ates_pkg::*;

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int COL_W = $clog2(COLS);
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PC_W  = $clog2(MAX_ARGS + 1);
   localparam int PI_W  = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam int SL_W  = $clog2(SEQ_WINDOW);
   localparam int NSTOP = COLS / TAB_STOP + 1;

   function automatic int clamp_hi(input int v, input int hi);
      int r;
      r = v;
      if (r < 0) r = 0;
      if (r > hi) r = hi;
      return r;
   endfunction

   function automatic logic [AW-1:0] cell_addr(input int row, input int col);
      return AW'(row * COLS + col);
   endfunction

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         last_ff, last_in;
   logic [AW-1:0]         rd_addr_ff, rd_addr_in;
   logic                  in_range_ff, in_range_in;
   logic [COL_W-1:0]      cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]      cur_row_ff, cur_row_in;
   logic [COL_W-1:0]      saved_col_ff, saved_col_in;
   logic [ROW_W-1:0]      saved_row_ff, saved_row_in;
   logic [COLOUR_W-1:0]   fg_ff, fg_in;
   logic [COLOUR_W-1:0]   bg_ff, bg_in;
   logic [STYLE_W-1:0]    style_ff, style_in;
   logic [PC_W-1:0]       pcount_ff, pcount_in;
   logic                  in_digits_ff, in_digits_in;
   logic                  void_ff, void_in;
   logic [SL_W-1:0]       seqlen_ff, seqlen_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [NUM_W-1:0]      p0_ff, p0_in;
   logic [NUM_W-1:0]      p1_ff, p1_in;
   logic [NUM_W-1:0]      pstore_ff [MAX_ARGS];
   logic                  ps_we;
   logic [PI_W-1:0]       ps_idx;
   logic [NUM_W-1:0]      ps_val;
   logic [PI_W-1:0]       sgr_i_ff, sgr_i_in;
   logic [PC_W-1:0]       sgr_n_ff, sgr_n_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]     rsp_attr_ff, rsp_attr_in;
   logic [COL_W-1:0]      rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]      rsp_row_ff, rsp_row_in;
   logic [COLOUR_W-1:0]   rsp_fg_ff, rsp_fg_in;
   logic [COLOUR_W-1:0]   rsp_bg_ff, rsp_bg_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [CELL_W-1:0]     ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [CELL_W-1:0]     ram_rdata;

   logic [BYTE_W-1:0]     b;
   logic                  accept;
   logic                  do_text;
   logic                  is_letter;
   logic                  rsp_free;
   logic [PC_W-1:0]       cnt_end;
   logic [NUM_W-1:0]      p0e;
   logic [NUM_W+3:0]      acc;
   logic [NUM_W-1:0]      sat;
   logic [NUM_W-1:0]      sgr_v;
   int                    tab_stop;

   ates_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign b        = req_if.data_byte;
   assign accept   = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign do_text  = (phase_ff == PH_TEXT) || ((phase_ff == PH_ESC) && (b != BYTE_LBRK));
   assign is_letter = (b inside {[BYTE_UC_A:BYTE_UC_Z], [BYTE_LC_A:BYTE_LC_Z]});
   assign cnt_end  = pcount_ff + PC_W'(in_digits_ff);
   assign p0e      = (cnt_end == '0) ? NUM_W'(1) : p0_ff;
   assign acc      = {num_ff, 3'b000} + {2'b00, num_ff, 1'b0} + (NUM_W+4)'(b - BYTE_D0);
   assign sat      = (acc > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : acc[NUM_W-1:0];
   assign sgr_v    = pstore_ff[sgr_i_ff];
   assign ram_raddr = (state_ff == ST_SCROLL) ? AW'(int'(cnt_ff) + COLS) : rd_addr_ff;

   always_comb begin
      tab_stop = NSTOP * TAB_STOP;
      for (int m = NSTOP; m >= 1; m--) begin
         if (m * TAB_STOP > int'(cur_col_ff)) tab_stop = m * TAB_STOP;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rd_addr_in   = rd_addr_ff;
      in_range_in  = in_range_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      saved_col_in = saved_col_ff;
      saved_row_in = saved_row_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      style_in     = style_ff;
      pcount_in    = pcount_ff;
      in_digits_in = in_digits_ff;
      void_in      = void_ff;
      seqlen_in    = seqlen_ff;
      num_in       = num_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      ps_we        = 1'b0;
      ps_idx       = pcount_ff[PI_W-1:0];
      ps_val       = sat;
      sgr_i_in     = sgr_i_ff;
      sgr_n_in     = sgr_n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_fg_in    = rsp_fg_ff;
      rsp_bg_in    = rsp_bg_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = {CHAR_SPACE, ATTR_W'(0)};

      case (state_ff)
         ST_FILL: begin
            ram_we = 1'b1;
            if (cnt_ff == last_ff) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_SCROLL: begin
            ram_we    = (cnt_ff != '0);
            ram_waddr = cnt_ff - AW'(1);
            ram_wdata = ram_rdata;
            if (int'(cnt_ff) == CELLS - COLS) begin
               state_in = ST_FILL;
               last_in  = AW'(CELLS - 1);
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = in_range_ff ? ram_rdata[CELL_W-1:ATTR_W] : CHAR_SPACE;
               rsp_attr_in  = in_range_ff ? ram_rdata[ATTR_W-1:0] : ATTR_W'(0);
               rsp_col_in   = cur_col_ff;
               rsp_row_in   = cur_row_ff;
               rsp_fg_in    = fg_ff;
               rsp_bg_in    = bg_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_SGR: begin
            if (sgr_v == SGR_RESET) begin
               style_in = '0;
               fg_in    = DEFAULT_COLOUR;
               bg_in    = DEFAULT_COLOUR;
            end else if (sgr_v == SGR_BOLD) begin
               style_in = style_ff | STYLE_BOLD;
            end else if (sgr_v == SGR_UNDER) begin
               style_in = style_ff | STYLE_UNDER;
            end else if (sgr_v == SGR_REV) begin
               style_in = style_ff | STYLE_REV;
            end else if (sgr_v inside {[SGR_FG_LO:SGR_FG_HI]}) begin
               fg_in = COLOUR_W'(sgr_v - SGR_FG_LO);
            end else if (sgr_v == SGR_FG_DF) begin
               fg_in = DEFAULT_COLOUR;
            end else if (sgr_v inside {[SGR_BG_LO:SGR_BG_HI]}) begin
               bg_in = COLOUR_W'(sgr_v - SGR_BG_LO);
            end else if (sgr_v == SGR_BG_DF) begin
               bg_in = DEFAULT_COLOUR;
            end
            if (PC_W'(sgr_i_ff) + PC_W'(1) >= sgr_n_ff) begin
               state_in = ST_IDLE;
            end else begin
               sgr_i_in = sgr_i_ff + PI_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept && req_if.cmd) begin
               in_range_in = (int'(req_if.read_row) < ROWS) && (int'(req_if.read_col) < COLS);
               rd_addr_in  = in_range_in ?
                             cell_addr(int'(req_if.read_row), int'(req_if.read_col)) : '0;
               state_in    = ST_READ;
            end else if (accept && do_text) begin
               phase_in = PH_TEXT;
               if (b == BYTE_ESC) begin
                  phase_in = PH_ESC;
               end else if (b == BYTE_CR) begin
                  cur_col_in = '0;
               end else if (b == BYTE_LF ||
                            (b == BYTE_TAB && tab_stop >= COLS) ||
                            (b inside {[BYTE_PR_LO:BYTE_PR_HI]} &&
                             int'(cur_col_ff) == COLS - 1)) begin
                  cur_col_in = '0;
                  if (int'(cur_row_ff) == ROWS - 1) begin
                     state_in = ST_SCROLL;
                     cnt_in   = '0;
                  end else begin
                     cur_row_in = cur_row_ff + ROW_W'(1);
                  end
               end else if (b == BYTE_TAB) begin
                  cur_col_in = COL_W'(tab_stop);
               end else if (b inside {[BYTE_PR_LO:BYTE_PR_HI]}) begin
                  cur_col_in = cur_col_ff + COL_W'(1);
               end
               if (b inside {[BYTE_PR_LO:BYTE_PR_HI]}) begin
                  ram_we    = 1'b1;
                  ram_waddr = cell_addr(int'(cur_row_ff), int'(cur_col_ff));
                  ram_wdata = {b[CHAR_W-1:0], fg_ff, 1'b0, style_ff};
               end
            end else if (accept && phase_ff == PH_ESC) begin
               phase_in     = PH_CSI;
               pcount_in    = '0;
               in_digits_in = 1'b0;
               void_in      = 1'b0;
               seqlen_in    = '0;
            end else if (accept && is_letter) begin
               phase_in     = PH_TEXT;
               in_digits_in = 1'b0;
               pcount_in    = cnt_end;
               if (cnt_end == '0) begin
                  pcount_in = PC_W'(1);
                  ps_we     = 1'b1;
                  ps_idx    = '0;
                  ps_val    = NUM_W'(1);
                  p0_in     = NUM_W'(1);
               end
               if (!void_ff) begin
                  case (b)
                     LT_UP: begin
                        cur_row_in = ROW_W'(clamp_hi(int'(cur_row_ff) - int'(p0e), ROWS - 1));
                     end
                     LT_DOWN: begin
                        cur_row_in = ROW_W'(clamp_hi(int'(cur_row_ff) + int'(p0e), ROWS - 1));
                     end
                     LT_RIGHT: begin
                        cur_col_in = COL_W'(clamp_hi(int'(cur_col_ff) + int'(p0e), COLS - 1));
                     end
                     LT_LEFT: begin
                        cur_col_in = COL_W'(clamp_hi(int'(cur_col_ff) - int'(p0e), COLS - 1));
                     end
                     LT_HOME, LT_HOME_F: begin
                        if (cnt_end >= PC_W'(2)) begin
                           cur_row_in = ROW_W'(clamp_hi(int'(p0_ff) - 1, ROWS - 1));
                           cur_col_in = COL_W'(clamp_hi(int'(p1_ff) - 1, COLS - 1));
                        end else begin
                           cur_row_in = '0;
                           cur_col_in = '0;
                        end
                     end
                     LT_CLEAR: begin
                        if (p0e == ARG_CLEAR_ALL) begin
                           state_in   = ST_FILL;
                           cnt_in     = '0;
                           last_in    = AW'(CELLS - 1);
                           cur_row_in = '0;
                           cur_col_in = '0;
                        end
                     end
                     LT_ERASE: begin
                        if (p0e == ARG_TO_END) begin
                           state_in = ST_FILL;
                           cnt_in   = cell_addr(int'(cur_row_ff), int'(cur_col_ff));
                           last_in  = cell_addr(int'(cur_row_ff), COLS - 1);
                        end
                     end
                     LT_SGR: begin
                        state_in = ST_SGR;
                        sgr_i_in = '0;
                        sgr_n_in = (cnt_end == '0) ? PC_W'(1) : cnt_end;
                     end
                     LT_SAVE: begin
                        saved_col_in = cur_col_ff;
                        saved_row_in = cur_row_ff;
                     end
                     LT_RESTORE: begin
                        cur_col_in = saved_col_ff;
                        cur_row_in = saved_row_ff;
                     end
                     default: begin
                     end
                  endcase
               end
            end else if (accept) begin
               if (b inside {[BYTE_D0:BYTE_D9]}) begin
                  if (in_digits_ff) begin
                     ps_we  = 1'b1;
                     num_in = sat;
                  end else if (int'(pcount_ff) < MAX_ARGS) begin
                     ps_we        = 1'b1;
                     ps_val       = NUM_W'(b - BYTE_D0);
                     num_in       = NUM_W'(b - BYTE_D0);
                     in_digits_in = 1'b1;
                  end else begin
                     void_in = 1'b1;
                  end
               end else if (b == BYTE_SEMI) begin
                  if (in_digits_ff) begin
                     in_digits_in = 1'b0;
                     pcount_in    = pcount_ff + PC_W'(1);
                  end else if (int'(pcount_ff) >= MAX_ARGS) begin
                     void_in = 1'b1;
                  end
               end else begin
                  void_in = 1'b1;
               end
               seqlen_in = seqlen_ff + SL_W'(1);
               if (int'(seqlen_ff) + 1 >= SEQ_WINDOW - 2) begin
                  phase_in = PH_TEXT;
               end
               if (ps_we && ps_idx == '0) p0_in = ps_val;
               if (ps_we && int'(ps_idx) == 1) p1_in = ps_val;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         phase_ff     <= PH_TEXT;
         cnt_ff       <= '0;
         last_ff      <= AW'(CELLS - 1);
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         saved_col_ff <= '0;
         saved_row_ff <= '0;
         fg_ff        <= DEFAULT_COLOUR;
         bg_ff        <= DEFAULT_COLOUR;
         style_ff     <= '0;
         pcount_ff    <= '0;
         in_digits_ff <= 1'b0;
         void_ff      <= 1'b0;
         seqlen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         saved_col_ff <= saved_col_in;
         saved_row_ff <= saved_row_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         style_ff     <= style_in;
         pcount_ff    <= pcount_in;
         in_digits_ff <= in_digits_in;
         void_ff      <= void_in;
         seqlen_ff    <= seqlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      in_range_ff <= in_range_in;
      num_ff      <= num_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      sgr_i_ff    <= sgr_i_in;
      sgr_n_ff    <= sgr_n_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_fg_ff   <= rsp_fg_in;
      rsp_bg_ff   <= rsp_bg_in;
      if (ps_we) begin
         pstore_ff[ps_idx] <= ps_val;
      end
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.cell_char   = rsp_char_ff;
   assign rsp_if.cell_attr   = rsp_attr_ff;
   assign rsp_if.cursor_col  = rsp_col_ff;
   assign rsp_if.cursor_row  = rsp_row_ff;
   assign rsp_if.fore_colour = rsp_fg_ff;
   assign rsp_if.back_colour = rsp_bg_ff;

   // cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      (int'(cur_row_ff) < ROWS) && (int'(cur_col_ff) < COLS))
      else $error("cursor off screen");

   // no screen writes while a cell read is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_LOAD) |-> !ram_we)
      else $error("screen write during cell read");

   // argument count never passes its limit
   assert property (@(posedge clock) disable iff (reset)
      int'(pcount_ff) <= MAX_ARGS)
      else $error("argument count overflow");

   // a cell read always ends in a response word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && rsp_free) |=> rsp_valid_ff)
      else $error("cell read lost");
endmodule

// ----- verif/tb_ansi_text_screen_engine.sv -----
`timescale 1ns / 1ps
module tb_ansi_text_screen_engine;
   import ates_pkg::*;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_word_t;

   typedef struct packed {
      logic [6:0] cell_char;
      logic [7:0] cell_attr;
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic [3:0] fore_colour;
      logic [3:0] back_colour;
   } rsp_word_t;

   localparam int NCOL = COLS_DEF;
   localparam int NROW = ROWS_DEF;
   localparam int NARG = MAX_ARGS_DEF;
   localparam int NCELL = NCOL * NROW;
   localparam int HOLD_LEN = 3000;
   localparam longint CYCLE_LIMIT = 64'd20000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   ates_req_if req_if ();
   ates_rsp_if rsp_if ();

   ansi_text_screen_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // screen predictor state
   phase_type   scr_phase;
   logic [15:0] scr_args [NARG];
   int          scr_nargs;
   bit          scr_digits, scr_void;
   int          scr_len;
   int          scr_col, scr_row, scr_scol, scr_srow;
   logic [3:0]  scr_fg, scr_bg;
   logic [2:0]  scr_style;
   logic [6:0]  scr_char [NCELL];
   logic [7:0]  scr_attr [NCELL];

   req_word_t pending_words [$];
   rsp_word_t expected_cells [$];
   int  send_idle_pct, recv_idle_pct;
   int  hold_left;
   bit  hold_go = 1'b0;
   bit  hold_done;
   int  errors = 0;
   int  reads_checked = 0;
   int  bytes_sent = 0;
   longint cycles = 0;

   function automatic void screen_reset();
      scr_phase = PH_TEXT;
      foreach (scr_args[i]) scr_args[i] = '0;
      scr_nargs = 0; scr_digits = 0; scr_void = 0; scr_len = 0;
      scr_col = 0; scr_row = 0; scr_scol = 0; scr_srow = 0;
      scr_fg = DEFAULT_COLOUR; scr_bg = DEFAULT_COLOUR; scr_style = '0;
      foreach (scr_char[i]) begin
         scr_char[i] = CHAR_SPACE;
         scr_attr[i] = '0;
      end
   endfunction

   function automatic void line_feed();
      scr_col = 0;
      scr_row++;
      if (scr_row >= NROW) begin
         for (int i = 0; i < NCELL - NCOL; i++) begin
            scr_char[i] = scr_char[i + NCOL];
            scr_attr[i] = scr_attr[i + NCOL];
         end
         for (int i = NCELL - NCOL; i < NCELL; i++) begin
            scr_char[i] = CHAR_SPACE;
            scr_attr[i] = '0;
         end
         scr_row = NROW - 1;
      end
   endfunction

   function automatic void move_to(int x, int y);
      scr_col = x < 0 ? 0 : (x >= NCOL ? NCOL - 1 : x);
      scr_row = y < 0 ? 0 : (y >= NROW ? NROW - 1 : y);
   endfunction

   function automatic void run_letter(logic [7:0] lt);
      int p0;
      logic [15:0] v;
      if (scr_nargs == 0) begin
         scr_args[0] = 16'd1;
         scr_nargs = 1;
      end
      p0 = scr_args[0];
      case (lt)
         LT_UP:    move_to(scr_col, scr_row - p0);
         LT_DOWN:  move_to(scr_col, scr_row + p0);
         LT_RIGHT: move_to(scr_col + p0, scr_row);
         LT_LEFT:  move_to(scr_col - p0, scr_row);
         LT_HOME, LT_HOME_F: begin
            if (scr_nargs >= 2) move_to(int'(scr_args[1]) - 1, p0 - 1);
            else move_to(0, 0);
         end
         LT_CLEAR: begin
            if (scr_args[0] == ARG_CLEAR_ALL) begin
               foreach (scr_char[i]) begin
                  scr_char[i] = CHAR_SPACE;
                  scr_attr[i] = '0;
               end
               scr_col = 0; scr_row = 0;
            end
         end
         LT_ERASE: begin
            if (scr_args[0] == ARG_TO_END)
               for (int i = scr_col; i < NCOL; i++) begin
                  scr_char[scr_row * NCOL + i] = CHAR_SPACE;
                  scr_attr[scr_row * NCOL + i] = '0;
               end
         end
         LT_SGR: begin
            for (int i = 0; i < scr_nargs && i < NARG; i++) begin
               v = scr_args[i];
               if (v == SGR_RESET) begin
                  scr_style = '0; scr_fg = DEFAULT_COLOUR; scr_bg = DEFAULT_COLOUR;
               end else if (v == SGR_BOLD) scr_style |= STYLE_BOLD;
               else if (v == SGR_UNDER) scr_style |= STYLE_UNDER;
               else if (v == SGR_REV) scr_style |= STYLE_REV;
               else if (v >= SGR_FG_LO && v <= SGR_FG_HI) scr_fg = 4'(v - SGR_FG_LO);
               else if (v == SGR_FG_DF) scr_fg = DEFAULT_COLOUR;
               else if (v >= SGR_BG_LO && v <= SGR_BG_HI) scr_bg = 4'(v - SGR_BG_LO);
               else if (v == SGR_BG_DF) scr_bg = DEFAULT_COLOUR;
            end
         end
         LT_SAVE: begin
            scr_scol = scr_col; scr_srow = scr_row;
         end
         LT_RESTORE: begin
            scr_col = scr_scol; scr_row = scr_srow;
         end
         default: ;
      endcase
   endfunction

   function automatic void close_number();
      if (scr_digits) begin
         scr_digits = 0;
         scr_nargs++;
      end
   endfunction

   function automatic void feed_byte(logic [7:0] b);
      int at, v;
      if (scr_phase == PH_ESC) begin
         if (b == BYTE_LBRK) begin
            scr_phase = PH_CSI;
            foreach (scr_args[i]) scr_args[i] = '0;
            scr_nargs = 0; scr_digits = 0; scr_void = 0; scr_len = 0;
            return;
         end
         scr_phase = PH_TEXT;
      end
      if (scr_phase == PH_CSI) begin
         if ((b >= BYTE_UC_A && b <= BYTE_UC_Z) || (b >= BYTE_LC_A && b <= BYTE_LC_Z)) begin
            close_number();
            scr_phase = PH_TEXT;
            if (!scr_void) run_letter(b);
            return;
         end
         if (b >= BYTE_D0 && b <= BYTE_D9) begin
            if (scr_digits) begin
               if (scr_nargs < NARG) begin
                  v = int'(scr_args[scr_nargs]) * 10 + int'(b - BYTE_D0);
                  scr_args[scr_nargs] = v > 65535 ? NUM_MAX : 16'(v);
               end
            end else if (scr_nargs < NARG) begin
               scr_args[scr_nargs] = 16'(b - BYTE_D0);
               scr_digits = 1;
            end else scr_void = 1;
         end else if (b == BYTE_SEMI) begin
            if (scr_digits) close_number();
            else if (scr_nargs >= NARG) scr_void = 1;
         end else scr_void = 1;
         scr_len++;
         if (scr_len >= SEQ_WINDOW_DEF - 2) scr_phase = PH_TEXT;
         return;
      end
      if (b == BYTE_ESC) begin
         scr_phase = PH_ESC;
         return;
      end
      if (b == BYTE_LF) line_feed();
      else if (b == BYTE_CR) scr_col = 0;
      else if (b == BYTE_TAB) begin
         scr_col = (scr_col / TAB_STOP_DEF + 1) * TAB_STOP_DEF;
         if (scr_col >= NCOL) line_feed();
      end else if (b >= BYTE_PR_LO && b <= BYTE_PR_HI) begin
         at = scr_row * NCOL + scr_col;
         scr_char[at] = b[6:0];
         scr_attr[at] = {scr_fg, 1'b0, scr_style};
         scr_col++;
         if (scr_col >= NCOL) line_feed();
      end
   endfunction

   function automatic rsp_word_t read_cell(logic [4:0] r, logic [6:0] c);
      rsp_word_t w;
      w.cell_char = CHAR_SPACE;
      w.cell_attr = '0;
      if (r < NROW && c < NCOL) begin
         w.cell_char = scr_char[r * NCOL + c];
         w.cell_attr = scr_attr[r * NCOL + c];
      end
      w.cursor_col = 7'(scr_col);
      w.cursor_row = 5'(scr_row);
      w.fore_colour = scr_fg;
      w.back_colour = scr_bg;
      return w;
   endfunction

   // stimulus builders
   function automatic void push_byte(logic [7:0] b);
      req_word_t w;
      w.cmd = 1'b0;
      w.data_byte = b;
      w.read_row = 5'($urandom);
      w.read_col = 7'($urandom);
      pending_words.push_back(w);
   endfunction

   function automatic void push_read(logic [4:0] r, logic [6:0] c);
      req_word_t w;
      w.cmd = 1'b1;
      w.data_byte = 8'($urandom);
      w.read_row = r;
      w.read_col = c;
      pending_words.push_back(w);
   endfunction

   function automatic void push_text(string s);
      foreach (s[i]) push_byte(s[i]);
   endfunction

   function automatic void push_random_read();
      if ($urandom_range(0, 7) == 0) push_read(5'($urandom), 7'($urandom));
      else push_read(5'($urandom_range(0, NROW - 1)), 7'($urandom_range(0, NCOL - 1)));
   endfunction

   function automatic void push_sequence();
      int n;
      string letters;
      letters = "ABCDHfJKmsuzQ";
      push_byte(BYTE_ESC);
      push_byte(BYTE_LBRK);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: push_text($sformatf("%0d", $urandom_range(0, 9)));
            1: push_text($sformatf("%0d", $urandom_range(0, 99)));
            2: push_text($sformatf("%0d", $urandom_range(30, 49)));
            3: push_text($sformatf("%0d", $urandom_range(0, 99999)));
            4: ;
            default: push_text($sformatf("%0d", $urandom_range(0, 7)));
         endcase
         if (i != n - 1) push_byte(BYTE_SEMI);
      end
      if ($urandom_range(0, 19) == 0) push_byte(8'($urandom));
      push_byte(letters[$urandom_range(0, letters.len() - 1)]);
   endfunction

   function automatic void push_random_burst();
      case ($urandom_range(0, 9))
         0, 1, 2: push_sequence();
         3, 4: for (int i = $urandom_range(1, 8); i > 0; i--)
            push_byte(8'($urandom_range(32, 126)));
         5: push_byte($urandom_range(0, 1) ? BYTE_LF : BYTE_CR);
         6: push_byte(BYTE_TAB);
         7: push_byte(8'($urandom));
         default: push_random_read();
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.cmd <= 1'b0;
         req_if.data_byte <= '0;
         req_if.read_row <= '0;
         req_if.read_col <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_word_t w;
            w = pending_words.pop_front();
            req_if.valid <= 1'b1;
            {req_if.cmd, req_if.data_byte, req_if.read_row, req_if.read_col} <= w;
            if (w.cmd) expected_cells.push_back(read_cell(w.read_row, w.read_col));
            else begin
               feed_byte(w.data_byte);
               bytes_sent++;
            end
         end else req_if.valid <= 1'b0;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) hold_left <= hold_left - 1;
      else if (hold_go && !hold_done) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_word_t got, want;
            got = {rsp_if.cell_char, rsp_if.cell_attr, rsp_if.cursor_col,
                   rsp_if.cursor_row, rsp_if.fore_colour, rsp_if.back_colour};
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               errors++;
            end else begin
               want = expected_cells.pop_front();
               reads_checked++;
               if (got !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
                  errors++;
               end
            end
         end
         if (hold_left > 0) rsp_if.ready <= 1'b0;
         else rsp_if.ready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic drain();
      while (pending_words.size() != 0 || req_if.valid || expected_cells.size() != 0)
         @(posedge clock);
      repeat (4 * NCELL) @(posedge clock);
   endtask

   initial begin
      send_idle_pct = 0; recv_idle_pct = 0;
      screen_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed
      push_read(0, 0);
      push_text("A~");
      push_byte(8'h7F); push_byte(8'hFF); push_byte(8'h00);
      push_byte(BYTE_ESC); push_text("[1;4;7;31;42m");
      push_text("Z"); push_byte(BYTE_TAB); push_byte(BYTE_LF);
      push_byte(BYTE_ESC); push_text("X");
      push_byte(BYTE_ESC); push_text("[99999;80H");
      push_read(0, 0); push_read(0, 1); push_read(23, 79); push_read(31, 127);
      push_byte(BYTE_ESC); push_text("[123456789012345678");
      push_read(0, 0);
      drain();
      push_byte(BYTE_ESC); push_text("[1;2;3;4;5;6;7;8;9;1;2;3;4;5;6;7;;8m");
      push_byte(BYTE_ESC); push_text("[s"); push_byte(BYTE_ESC); push_text("[5B");
      push_byte(BYTE_ESC); push_text("[u"); push_byte(BYTE_ESC); push_text("[0K");
      push_byte(BYTE_ESC); push_text("[2J"); push_byte(BYTE_ESC); push_text("[0m");
      push_read(1, 0);

      // random phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 6 : (ph == 1 ? 85 : 0);
         recv_idle_pct = ph == 0 ? 85 : (ph == 1 ? 6 : 0);
         if (ph == 2) hold_go = 1'b1;
         for (int i = 0; i < 100; i++) push_random_burst();
         drain();
      end
      $display("sent %0d stream bytes, checked %0d cell reads", bytes_sent, reads_checked);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
